// ===== hw/rtl/srd_pkg.sv =====
package srd_pkg;

    localparam int SRD_QUEUE_DEPTH = 2;

    localparam logic [4:0] SRD_CODE_TIME   = 5'd2;
    localparam logic [4:0] SRD_CODE_PERIOD = 5'd5;
    localparam logic [4:0] SRD_CODE_RECORD = 5'd24;
    localparam logic [4:0] SRD_CODE_BLOCK  = 5'd25;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CATEGORY  = 3'd1;
    localparam logic [2:0] ERR_LENGTH    = 3'd2;
    localparam logic [2:0] ERR_EXTENT    = 3'd3;
    localparam logic [2:0] ERR_SPARE     = 3'd4;
    localparam logic [2:0] ERR_EXTENSION = 3'd5;
    localparam logic [2:0] ERR_OVERRUN   = 3'd6;
    localparam logic [2:0] ERR_ZERO_SKIP = 3'd7;

    localparam logic [7:0] SRD_RESET_CATEGORY = 8'd13;

    // One result word as it travels from the front to the back.
    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic        rec;
        logic        bd;
        logic [2:0]  err;
        logic        trail;
    } srd_entry_t;

    typedef struct packed {
        logic       push;
        srd_entry_t entry;
    } srd_push_t;

    function automatic logic [7:0] srd_item_len(input logic [4:0] idx);
        logic [7:0] len;
        case (idx)
            5'd0:    len = 8'd2;
            5'd1:    len = 8'd1;
            5'd2:    len = 8'd3;
            5'd3:    len = 8'd1;
            5'd4:    len = 8'd2;
            5'd5:    len = 8'd2;
            5'd6:    len = 8'd2;
            5'd7:    len = 8'd1;
            5'd8:    len = 8'd8;
            5'd9:    len = 8'd1;
            5'd10:   len = 8'd1;
            5'd11:   len = 8'd1;
            5'd12:   len = 8'd8;
            5'd13:   len = 8'd8;
            5'd14:   len = 8'd2;
            5'd15:   len = 8'd4;
            5'd16:   len = 8'd2;
            5'd17:   len = 8'd6;
            5'd18:   len = 8'd2;
            5'd19:   len = 8'd2;
            5'd20:   len = 8'd2;
            5'd21:   len = 8'd2;
            5'd22:   len = 8'd1;
            5'd23:   len = 8'd4;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/srd_front.sv =====
module srd_front
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output srd_push_t   push_out
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FSPEC,
        PH_PRIM,
        PH_DATA,
        PH_SKIPLEN,
        PH_SKIP,
        PH_DISCARD,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic       found;
        logic       prim;
        logic [4:0] idx;
        logic       ig;
    } walk_t;

    // Find the next present element at or after position c.
    function automatic walk_t srd_walk(input logic [4:0] c, input logic [7:0] f0,
                                       input logic [7:0] f1, input logic [7:0] f2,
                                       input logic [7:0] cp, input logic ig);
        walk_t      w;
        logic [25:0] hit;
        logic       ga;
        logic       gb;
        ga = ig && (c <= 5'd12);
        gb = ig && (c >= 5'd17) && (c <= 5'd22);
        for (int p = 0; p < 7; p++)
            hit[p] = f0[7 - p];
        hit[7]  = ga ? cp[7] : f1[7];
        hit[8]  = ga && cp[5];
        hit[9]  = ga && cp[4];
        hit[10] = ga && cp[3];
        hit[11] = ga && cp[2];
        hit[12] = ga && cp[1];
        hit[13] = f1[6];
        hit[14] = f1[5];
        hit[15] = f1[4];
        hit[16] = f1[3];
        hit[17] = gb ? cp[7] : f1[2];
        hit[18] = gb && cp[6];
        hit[19] = gb && cp[5];
        hit[20] = gb && cp[4];
        hit[21] = gb && cp[3];
        hit[22] = gb && cp[1];
        hit[23] = f1[1];
        hit[24] = f2[2];
        hit[25] = f2[1];
        w = '0;
        for (int p = 25; p >= 0; p--)
        begin
            if (hit[p] && (5'(p) >= c))
            begin
                w.found = 1'b1;
                w.idx   = 5'(p);
            end
        end
        w.prim = ((w.idx == 5'd7) && !ga) || ((w.idx == 5'd17) && !gb);
        w.ig   = (ga && w.idx >= 5'd7 && w.idx <= 5'd12)
              || (gb && w.idx >= 5'd17 && w.idx <= 5'd22);
        return w;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  hcount_reg, hcount_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  fspec_reg [3];
    logic [7:0]  fspec_next [3];
    logic [1:0]  fidx_reg, fidx_next;
    logic [7:0]  cp_reg, cp_next;
    logic [4:0]  elem_reg, elem_next;
    logic [7:0]  left_reg, left_next;
    logic [63:0] asm_reg, asm_next;
    logic [2:0]  ekind_reg, ekind_next;
    logic        ig_reg, ig_next;
    logic [7:0]  cat_reg;

    logic [2:0]  err;
    logic        emitted, rec, entry_tail, complete, at_end, do_walk, clear;
    logic [4:0]  ecode, walk_c;
    logic [63:0] evalue;
    logic [7:0]  fw [3];
    logic [7:0]  cp_w;
    logic        ig_w;
    logic        fx;
    walk_t       wk;
    srd_push_t   po;

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        fspec_next  = fspec_reg;
        fidx_next   = fidx_reg;
        cp_next     = cp_reg;
        elem_next   = elem_reg;
        left_next   = left_reg;
        asm_next    = asm_reg;
        ekind_next  = ekind_reg;
        ig_next     = ig_reg;
        err         = ERR_NONE;
        emitted     = 1'b0;
        rec         = 1'b0;
        entry_tail  = 1'b0;
        complete    = 1'b0;
        at_end      = 1'b0;
        do_walk     = 1'b0;
        clear       = 1'b0;
        ecode       = '0;
        evalue      = '0;
        walk_c      = '0;
        fw          = fspec_reg;
        cp_w        = cp_reg;
        ig_w        = ig_reg;
        fx          = data_byte[0];
        wk          = '0;
        po          = '0;

        if (accept)
        begin
            if (phase_reg == PH_DISCARD)
            begin
                if (last_byte)
                begin
                    po.push  = 1'b1;
                    po.entry = '{code: SRD_CODE_BLOCK, value: '0, rec: 1'b0, bd: 1'b1,
                                 err: ekind_reg, trail: 1'b0};
                    clear    = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        case (hcount_reg)
                            2'd0:
                            begin
                                if (data_byte != cat_reg)
                                    err = ERR_CATEGORY;
                                else
                                    hcount_next = 2'd1;
                            end
                            2'd1:
                            begin
                                len_next    = {data_byte, 8'h00};
                                hcount_next = 2'd2;
                            end
                            default:
                            begin
                                len_next    = {len_reg[15:8], data_byte};
                                pos_next    = 16'd3;
                                hcount_next = 2'd3;
                                if (len_next < 16'd3)
                                    err = ERR_LENGTH;
                                else if (len_next == 16'd3)
                                    phase_next = PH_TAIL;
                                else
                                begin
                                    fspec_next = '{default: 8'h00};
                                    fidx_next  = '0;
                                    cp_next    = '0;
                                    ig_next    = 1'b0;
                                    phase_next = PH_FSPEC;
                                end
                            end
                        endcase
                    end
                    PH_TAIL:
                        entry_tail = 1'b1;
                    default:
                    begin
                        pos_next = pos_reg + 16'd1;
                        at_end   = (pos_next == len_reg);
                        case (phase_reg)
                            PH_FSPEC:
                            begin
                                fw[fidx_reg] = data_byte;
                                if (fx && at_end)
                                    err = ERR_EXTENT;
                                else if (fidx_reg >= 2'd2 && |data_byte[7:3])
                                    err = ERR_SPARE;
                                else if (fidx_reg >= 2'd2 && fx)
                                    err = ERR_EXTENSION;
                                else if (fx)
                                    fidx_next = fidx_reg + 2'd1;
                                else
                                begin
                                    do_walk = 1'b1;
                                    walk_c  = 5'd0;
                                end
                            end
                            PH_PRIM:
                            begin
                                if (fx && at_end)
                                    err = ERR_EXTENT;
                                else if ((elem_reg == 5'd7) ? data_byte[6] : data_byte[2])
                                    err = ERR_SPARE;
                                else if (fx)
                                    err = ERR_EXTENSION;
                                else
                                begin
                                    cp_w    = data_byte;
                                    ig_w    = 1'b1;
                                    do_walk = 1'b1;
                                    walk_c  = elem_reg;
                                end
                            end
                            PH_DATA:
                            begin
                                asm_next  = {asm_reg[55:0], data_byte};
                                left_next = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
                                if (left_next == 8'd0)
                                begin
                                    emitted = 1'b1;
                                    ecode   = elem_reg;
                                    evalue  = asm_next;
                                    do_walk = 1'b1;
                                    walk_c  = elem_reg + 5'd1;
                                end
                            end
                            PH_SKIPLEN:
                            begin
                                if (data_byte == 8'd0)
                                    err = ERR_ZERO_SKIP;
                                else if (data_byte == 8'd1)
                                begin
                                    do_walk = 1'b1;
                                    walk_c  = elem_reg + 5'd1;
                                end
                                else
                                begin
                                    left_next  = data_byte - 8'd1;
                                    phase_next = PH_SKIP;
                                end
                            end
                            default:
                            begin
                                left_next = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
                                if (left_next == 8'd0)
                                begin
                                    do_walk = 1'b1;
                                    walk_c  = elem_reg + 5'd1;
                                end
                            end
                        endcase

                        fspec_next = fw;
                        cp_next    = cp_w;
                        ig_next    = ig_w;
                        if (do_walk)
                        begin
                            wk = srd_walk(walk_c, fw[0], fw[1], fw[2], cp_w, ig_w);
                            if (!wk.found)
                                complete = 1'b1;
                            else
                            begin
                                ig_next   = wk.ig;
                                elem_next = wk.idx;
                                if (wk.prim)
                                    phase_next = PH_PRIM;
                                else if (wk.idx >= SRD_CODE_RECORD)
                                    phase_next = PH_SKIPLEN;
                                else
                                begin
                                    phase_next = PH_DATA;
                                    left_next  = srd_item_len(wk.idx);
                                    asm_next   = '0;
                                end
                            end
                        end

                        if (err == ERR_NONE)
                        begin
                            if (complete)
                            begin
                                rec = 1'b1;
                                if (!emitted)
                                begin
                                    emitted = 1'b1;
                                    ecode   = SRD_CODE_RECORD;
                                    evalue  = '0;
                                end
                                if (at_end)
                                    phase_next = PH_TAIL;
                                else
                                begin
                                    fspec_next = '{default: 8'h00};
                                    fidx_next  = '0;
                                    cp_next    = '0;
                                    ig_next    = 1'b0;
                                    phase_next = PH_FSPEC;
                                end
                            end
                            else if (at_end)
                                err = ERR_OVERRUN;
                        end
                    end
                endcase

                if (err == ERR_NONE && last_byte && phase_next != PH_TAIL)
                    err = ERR_LENGTH;

                if (err != ERR_NONE)
                begin
                    po.push  = 1'b1;
                    po.entry = '{code: SRD_CODE_BLOCK, value: '0, rec: 1'b0, bd: last_byte,
                                 err: err, trail: 1'b0};
                    if (last_byte)
                        clear = 1'b1;
                    else
                    begin
                        phase_next = PH_DISCARD;
                        ekind_next = err;
                    end
                end
                else if (last_byte)
                begin
                    po.push  = 1'b1;
                    po.entry = '{code: emitted ? ecode : SRD_CODE_BLOCK,
                                 value: emitted ? evalue : 64'd0, rec: rec, bd: 1'b1,
                                 err: ERR_NONE, trail: entry_tail};
                    clear    = 1'b1;
                end
                else if (emitted)
                begin
                    po.push  = 1'b1;
                    po.entry = '{code: ecode, value: evalue, rec: rec, bd: 1'b0,
                                 err: ERR_NONE, trail: 1'b0};
                end
            end
        end

        if (clear)
        begin
            phase_next  = PH_HEADER;
            hcount_next = '0;
            len_next    = '0;
            pos_next    = '0;
            fspec_next  = '{default: 8'h00};
            fidx_next   = '0;
            cp_next     = '0;
            elem_next   = '0;
            left_next   = '0;
            asm_next    = '0;
            ekind_next  = ERR_NONE;
            ig_next     = 1'b0;
        end
    end

    assign push_out = po;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            fspec_reg  <= '{default: 8'h00};
            fidx_reg   <= '0;
            cp_reg     <= '0;
            elem_reg   <= '0;
            left_reg   <= '0;
            asm_reg    <= '0;
            ekind_reg  <= ERR_NONE;
            ig_reg     <= 1'b0;
            cat_reg    <= SRD_RESET_CATEGORY;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            fspec_reg  <= fspec_next;
            fidx_reg   <= fidx_next;
            cp_reg     <= cp_next;
            elem_reg   <= elem_next;
            left_reg   <= left_next;
            asm_reg    <= asm_next;
            ekind_reg  <= ekind_next;
            ig_reg     <= ig_next;
            if (cfg_we)
                cat_reg <= cfg_wdata;
        end
    end

endmodule

// ===== hw/rtl/srd_queue.sv =====
module srd_queue
    import srd_pkg::*;
#(
    parameter int DEPTH = SRD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  srd_push_t  push_in,
    input  logic       pop,
    output srd_entry_t head,
    output logic       empty,
    output logic       full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    srd_entry_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign head    = mem_reg[rd_reg];
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (do_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_in.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/srd_back.sv =====
module srd_back
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  srd_entry_t  head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  item_code,
    output logic [63:0] item_value,
    output logic        record_done,
    output logic        block_done,
    output logic [2:0]  error_code,
    output logic        trailing_ignored
);

    logic        valid_reg;
    srd_entry_t  out_reg, out_next;
    logic [34:0] prod;

    assign pop = !empty && (!valid_reg || !out_stall);

    // Time and period go out in milliseconds, rounded.
    assign prod = {11'd0, head.value[23:0]} * 35'd1000 + 35'd64;

    always_comb
    begin
        out_next = head;
        if (head.code == SRD_CODE_TIME || head.code == SRD_CODE_PERIOD)
            out_next.value = {36'd0, prod[34:7]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

    assign out_valid        = valid_reg;
    assign item_code        = out_reg.code;
    assign item_value       = out_reg.value;
    assign record_done      = out_reg.rec;
    assign block_done       = out_reg.bd;
    assign error_code       = out_reg.err;
    assign trailing_ignored = out_reg.trail;

endmodule

// ===== hw/rtl/surveillance_record_decoder.sv =====
// Byte-stream decoder for category 013 style surveillance data blocks. One byte is taken
// per clock while in_stall is low; the front decodes it in the cycle it is accepted and
// queues at most one result word, which passes through the queue memory to the output
// register unless older words are still held back by out_stall. Sustained rate is one
// byte per cycle while in_stall is low, set by the front parser; the result queue
// (QUEUE_DEPTH words) absorbs output stalls, and in_stall rises only when it is full.
// Errors report code 25 with the error kind; the block should then be discarded.
module surveillance_record_decoder
    import srd_pkg::*;
#(
    parameter int QUEUE_DEPTH = SRD_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  item_code,
    output logic [63:0] item_value,
    output logic        record_done,
    output logic        block_done,
    output logic [2:0]  error_code,
    output logic        trailing_ignored
);

    srd_push_t  push;
    srd_entry_t head;
    logic       empty, full, pop, accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    srd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push_out  (push)
    );

    srd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    srd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (empty),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .item_code        (item_code),
        .item_value       (item_value),
        .record_done      (record_done),
        .block_done       (block_done),
        .error_code       (error_code),
        .trailing_ignored (trailing_ignored)
    );

endmodule

// ===== hw/rtl/srd_checker.sv =====
module srd_checker
    import srd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  item_code,
    input logic [63:0] item_value,
    input logic        record_done,
    input logic        block_done,
    input logic [2:0]  error_code,
    input logic        trailing_ignored
);

    // Hold a stalled word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(item_code) && $stable(item_value))
        else $error("output word changed while stalled");

    a_err_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |->
            item_code == SRD_CODE_BLOCK && !record_done && !trailing_ignored)
        else $error("error word malformed");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_code == SRD_CODE_RECORD || item_code == SRD_CODE_BLOCK) |->
            item_value == 64'd0)
        else $error("marker word carries a value");

    a_trail_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trailing_ignored |-> block_done)
        else $error("trailing flag off block end");

endmodule

bind surveillance_record_decoder srd_checker u_srd_checker (.*);
